FILE: sv/tfst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_pkg
// Shared types and constants for the tcp flow sequence tracker.
// ----------------------------------------------------------------------------
package tfst_pkg;

  localparam int ETH_HEADER_BYTES_DEF = 14;

  // field offsets from the start of the ip header
  localparam int IP_TOT_LEN_HI_OFS = 2;
  localparam int IP_TOT_LEN_LO_OFS = 3;
  localparam int IP_PROTO_OFS      = 9;
  localparam int IP_SRC_FIRST_OFS  = 12;
  localparam int IP_SRC_LAST_OFS   = 15;

  // field offsets from the start of the tcp header
  localparam logic [15:0] TCP_SEQ_FIRST_OFS = 16'd4;
  localparam logic [15:0] TCP_SEQ_LAST_OFS  = 16'd7;
  localparam logic [15:0] TCP_ACK_FIRST_OFS = 16'd8;
  localparam logic [15:0] TCP_ACK_LAST_OFS  = 16'd11;
  localparam logic [15:0] TCP_DOFF_OFS      = 16'd12;
  localparam logic [15:0] TCP_FLAGS_OFS     = 16'd13;

  localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
  localparam logic [7:0] IP_PROTO_TCP  = 8'h06;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  // per-frame summary handed from the parser to the result stage
  typedef struct packed {
    logic        matched;
    logic [3:0]  ip_header_words;
    logic [3:0]  tcp_header_words;
    logic [15:0] ip_total_length;
    logic [31:0] raw_seq;
    logic [31:0] raw_ack;
    logic        syn_fin;
  } tfst_summary_t;

endpackage

FILE: sv/tcp_flow_seq_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_flow_seq_tracker_core
// Ethernet/IPv4/TCP header tracker with next-sequence computation.
// ----------------------------------------------------------------------------
// Frame bytes enter one per cycle in wire order while in_stall is low, the
// final byte of each frame marked by in_last_byte. Each byte passes an
// input register, then the parser, which matches its position against the
// header field offsets. No result appears for ordinary bytes; the last byte
// of a frame yields exactly one result item, which passes the input register,
// the frame summary register and the output register in that order, and the chain
// keeps taking one byte per cycle as long as the output side is not stalled.
// A result has out_matched set only for an IPv4 TCP frame from the configured
// source address that reached the TCP flags byte; otherwise the other result
// fields are zero. cfg_wr_data is written on cfg_wr_en and must only change
// while no frame is in flight.
// ----------------------------------------------------------------------------
module tcp_flow_seq_tracker_core #(
  parameter int ETH_HEADER_BYTES = tfst_pkg::ETH_HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_matched,
  output logic [31:0] out_next_seq,
  output logic [31:0] out_ack_number,
  output logic [15:0] out_payload_bytes,
  output logic        out_syn_or_fin
);

  logic [31:0] victim_ip_r;
  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r;
  logic        in_last_r;

  logic        accept;
  logic        parse_ready;
  logic        parse_fire;
  logic        sum_valid;
  logic        sum_ready;
  tfst_pkg::tfst_summary_t sum;

  assign parse_fire = in_valid_r && parse_ready;
  assign in_stall   = in_valid_r && !parse_ready;
  assign accept     = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (parse_fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      victim_ip_r <= '0;
      in_valid_r  <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (cfg_wr_en) victim_ip_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  tfst_parse #(
    .ETH_HEADER_BYTES(ETH_HEADER_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .victim_ip  (victim_ip_r),
    .item_valid (in_valid_r),
    .item_byte  (in_byte_r),
    .item_last  (in_last_r),
    .item_ready (parse_ready),
    .sum_valid  (sum_valid),
    .sum        (sum),
    .sum_ready  (sum_ready)
  );

  tfst_result u_result (
    .clk               (clk),
    .rst_n             (rst_n),
    .sum_valid         (sum_valid),
    .sum               (sum),
    .sum_ready         (sum_ready),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_matched       (out_matched),
    .out_next_seq      (out_next_seq),
    .out_ack_number    (out_ack_number),
    .out_payload_bytes (out_payload_bytes),
    .out_syn_or_fin    (out_syn_or_fin)
  );

endmodule

FILE: sv/tfst_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_parse
// Byte-position header field capture; emits a frame summary on the last byte.
// ----------------------------------------------------------------------------
module tfst_parse #(
  parameter int ETH_HEADER_BYTES = tfst_pkg::ETH_HEADER_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [31:0]            victim_ip,
  input  logic                   item_valid,
  input  logic [7:0]             item_byte,
  input  logic                   item_last,
  output logic                   item_ready,
  output logic                   sum_valid,
  output tfst_pkg::tfst_summary_t sum,
  input  logic                   sum_ready
);

  localparam logic [15:0] IP0        = 16'(ETH_HEADER_BYTES);
  localparam logic [15:0] ETYPE_HI_P = 16'(ETH_HEADER_BYTES - 2);
  localparam logic [15:0] ETYPE_LO_P = 16'(ETH_HEADER_BYTES - 1);
  localparam logic [15:0] TLEN_HI_P  = 16'(ETH_HEADER_BYTES + tfst_pkg::IP_TOT_LEN_HI_OFS);
  localparam logic [15:0] TLEN_LO_P  = 16'(ETH_HEADER_BYTES + tfst_pkg::IP_TOT_LEN_LO_OFS);
  localparam logic [15:0] PROTO_P    = 16'(ETH_HEADER_BYTES + tfst_pkg::IP_PROTO_OFS);
  localparam logic [15:0] SRC_FIRST_P = 16'(ETH_HEADER_BYTES + tfst_pkg::IP_SRC_FIRST_OFS);
  localparam logic [15:0] SRC_LAST_P  = 16'(ETH_HEADER_BYTES + tfst_pkg::IP_SRC_LAST_OFS);

  logic [15:0] pos_r, pos_nxt;
  logic        ether_ok_r, ether_ok_nxt;
  logic        proto_ok_r, proto_ok_nxt;
  logic        src_match_r, src_match_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [15:0] tot_len_r, tot_len_nxt;
  logic [3:0]  tcp_words_r, tcp_words_nxt;
  logic        syn_fin_r, syn_fin_nxt;
  logic        tcp_done_r, tcp_done_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] ack_r, ack_nxt;

  logic        sum_valid_r, sum_valid_nxt;
  tfst_pkg::tfst_summary_t sum_r;

  logic        fire;
  logic [1:0]  src_idx;
  logic [7:0]  src_byte;
  logic [15:0] t0;
  logic [15:0] tidx;
  logic        in_tcp;
  logic        matched;

  assign item_ready = !item_last || !sum_valid_r || sum_ready;
  assign fire       = item_valid && item_ready;

  always_comb begin
    ether_ok_nxt  = ether_ok_r;
    proto_ok_nxt  = proto_ok_r;
    src_match_nxt = src_match_r;
    ihl_nxt       = ihl_r;
    tot_len_nxt   = tot_len_r;
    tcp_words_nxt = tcp_words_r;
    syn_fin_nxt   = syn_fin_r;
    tcp_done_nxt  = tcp_done_r;
    seq_nxt       = seq_r;
    ack_nxt       = ack_r;

    if (pos_r == ETYPE_HI_P) ether_ok_nxt = (item_byte == tfst_pkg::ETYPE_IPV4_HI);
    if (pos_r == ETYPE_LO_P) ether_ok_nxt = ether_ok_r && (item_byte == tfst_pkg::ETYPE_IPV4_LO);
    if (pos_r == IP0) ihl_nxt = item_byte[3:0];
    if (pos_r == TLEN_HI_P) tot_len_nxt = {item_byte, 8'h00};
    if (pos_r == TLEN_LO_P) tot_len_nxt = {tot_len_r[15:8], item_byte};
    if (pos_r == PROTO_P) proto_ok_nxt = ether_ok_r && (item_byte == tfst_pkg::IP_PROTO_TCP);

    // source address arrives msb first
    src_idx  = 2'(pos_r - SRC_FIRST_P);
    src_byte = 8'(victim_ip >> {~src_idx, 3'b000});
    if (pos_r >= SRC_FIRST_P && pos_r <= SRC_LAST_P) begin
      if (src_idx == 2'd0) begin
        src_match_nxt = (src_byte == item_byte);
      end else begin
        src_match_nxt = src_match_r && (src_byte == item_byte);
      end
    end

    // ihl only changes at the ip header start, where no tcp field can fall
    t0     = IP0 + {10'd0, ihl_r, 2'b00};
    tidx   = pos_r - t0;
    in_tcp = (pos_r >= t0);
    if (in_tcp && tidx >= tfst_pkg::TCP_SEQ_FIRST_OFS && tidx <= tfst_pkg::TCP_SEQ_LAST_OFS) begin
      seq_nxt = {seq_r[23:0], item_byte};
    end
    if (in_tcp && tidx >= tfst_pkg::TCP_ACK_FIRST_OFS && tidx <= tfst_pkg::TCP_ACK_LAST_OFS) begin
      ack_nxt = {ack_r[23:0], item_byte};
    end
    if (in_tcp && tidx == tfst_pkg::TCP_DOFF_OFS) tcp_words_nxt = item_byte[7:4];
    if (in_tcp && tidx == tfst_pkg::TCP_FLAGS_OFS) begin
      syn_fin_nxt  = (item_byte[1:0] != 2'b00);
      tcp_done_nxt = 1'b1;
    end

    pos_nxt = (pos_r == tfst_pkg::POS_MAX) ? pos_r : pos_r + 16'd1;

    matched = ether_ok_nxt && proto_ok_nxt && src_match_nxt && tcp_done_nxt &&
              (pos_r >= SRC_LAST_P);
  end

  always_comb begin
    sum_valid_nxt = sum_valid_r;
    if (sum_valid_r && sum_ready) sum_valid_nxt = 1'b0;
    if (fire && item_last) sum_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      ether_ok_r  <= 1'b0;
      proto_ok_r  <= 1'b0;
      src_match_r <= 1'b0;
      ihl_r       <= '0;
      tot_len_r   <= '0;
      tcp_words_r <= '0;
      syn_fin_r   <= 1'b0;
      tcp_done_r  <= 1'b0;
      seq_r       <= '0;
      ack_r       <= '0;
      sum_valid_r <= 1'b0;
    end else begin
      sum_valid_r <= sum_valid_nxt;
      if (fire && item_last) begin
        pos_r       <= '0;
        ether_ok_r  <= 1'b0;
        proto_ok_r  <= 1'b0;
        src_match_r <= 1'b0;
        ihl_r       <= '0;
        tot_len_r   <= '0;
        tcp_words_r <= '0;
        syn_fin_r   <= 1'b0;
        tcp_done_r  <= 1'b0;
        seq_r       <= '0;
        ack_r       <= '0;
      end else if (fire) begin
        pos_r       <= pos_nxt;
        ether_ok_r  <= ether_ok_nxt;
        proto_ok_r  <= proto_ok_nxt;
        src_match_r <= src_match_nxt;
        ihl_r       <= ihl_nxt;
        tot_len_r   <= tot_len_nxt;
        tcp_words_r <= tcp_words_nxt;
        syn_fin_r   <= syn_fin_nxt;
        tcp_done_r  <= tcp_done_nxt;
        seq_r       <= seq_nxt;
        ack_r       <= ack_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && item_last) begin
      sum_r.matched          <= matched;
      sum_r.ip_header_words  <= ihl_nxt;
      sum_r.tcp_header_words <= tcp_words_nxt;
      sum_r.ip_total_length  <= tot_len_nxt;
      sum_r.raw_seq          <= seq_nxt;
      sum_r.raw_ack          <= ack_nxt;
      sum_r.syn_fin          <= syn_fin_nxt;
    end
  end

  assign sum_valid = sum_valid_r;
  assign sum       = sum_r;

endmodule

FILE: sv/tfst_result.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfst_result
// Payload length and next sequence number, held in the output register.
// ----------------------------------------------------------------------------
module tfst_result (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    sum_valid,
  input  tfst_pkg::tfst_summary_t sum,
  output logic                    sum_ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_matched,
  output logic [31:0]             out_next_seq,
  output logic [31:0]             out_ack_number,
  output logic [15:0]             out_payload_bytes,
  output logic                    out_syn_or_fin
);

  logic        out_valid_r, out_valid_nxt;
  logic        matched_r;
  logic [31:0] next_seq_r;
  logic [31:0] ack_r;
  logic [15:0] payload_r;
  logic        syn_fin_r;

  logic        load;
  logic [6:0]  hdrs;
  logic [15:0] pay;
  logic [31:0] nxt;

  assign sum_ready = !out_valid_r || !out_stall;
  assign load      = sum_valid && sum_ready;

  always_comb begin
    hdrs = {1'b0, sum.ip_header_words, 2'b00} + {1'b0, sum.tcp_header_words, 2'b00};
    // floored at zero when the headers run past the ip total length
    pay  = (sum.ip_total_length >= {9'd0, hdrs}) ?
           (sum.ip_total_length - {9'd0, hdrs}) : 16'd0;
    nxt  = sum.raw_seq + {16'd0, pay} + {31'd0, sum.syn_fin};
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      matched_r  <= sum.matched;
      next_seq_r <= sum.matched ? nxt : 32'd0;
      ack_r      <= sum.matched ? sum.raw_ack : 32'd0;
      payload_r  <= sum.matched ? pay : 16'd0;
      syn_fin_r  <= sum.matched && sum.syn_fin;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_matched       = matched_r;
  assign out_next_seq      = next_seq_r;
  assign out_ack_number    = ack_r;
  assign out_payload_bytes = payload_r;
  assign out_syn_or_fin    = syn_fin_r;

endmodule
